FILE: src/rpv_pkg.sv
// Shared types, constants and table helpers for the vertex rotation and projection block.
`timescale 1ns / 1ps
`default_nettype none

package rpv_pkg;

    // Default number of fraction bits held in sine values and rotated coordinates.
    localparam int SINE_FRAC_BITS_DEFAULT = 14;

    // Field widths of the transactions.
    localparam int COORD_W   = 12;
    localparam int ANGLE_W   = 9;
    localparam int SCREEN_W  = 16;
    localparam int DEPTH_W   = 14;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FIELD_OF_VIEW   = 3'd0,
        REG_CAMERA_DISTANCE = 3'd1,
        REG_SCREEN_X_OFFSET = 3'd2,
        REG_SCREEN_Y_OFFSET = 3'd3,
        REG_MODEL_CENTER_X  = 3'd4,
        REG_MODEL_CENTER_Y  = 3'd5
    } cfg_reg_t;

    // Reset values of the configuration registers.
    localparam logic [CFG_W-1:0] FOV_RESET      = 12'd356;
    localparam logic [CFG_W-1:0] CAM_RESET      = 12'd550;
    localparam logic [CFG_W-1:0] OFFSET_X_RESET = 12'd64;
    localparam logic [CFG_W-1:0] OFFSET_Y_RESET = 12'd32;
    localparam logic [CFG_W-1:0] CENTER_X_RESET = 12'd120;
    localparam logic [CFG_W-1:0] CENTER_Y_RESET = 12'd80;

    // Angle constants in whole degrees.
    localparam logic [9:0] DEG_90  = 10'd90;
    localparam logic [9:0] DEG_180 = 10'd180;
    localparam logic [9:0] DEG_270 = 10'd270;
    localparam logic [9:0] DEG_360 = 10'd360;

    // Quarter-wave sine table in millionths.
    localparam int SINE_ENTRIES = 91;
    localparam int SINE_IDX_W   = 7;
    localparam int SINE_SCALE   = 1000000;
    localparam int unsigned QUARTER_SINE [0:SINE_ENTRIES-1] = '{
        0, 17452, 34899, 52335, 69756, 87155, 104528, 121869, 139173,
        156434, 173648, 190808, 207911, 224951, 241921, 258819, 275637, 292371,
        309016, 325568, 342020, 358367, 374606, 390731, 406736, 422618, 438371,
        453990, 469471, 484809, 499999, 515038, 529919, 544639, 559192, 573576,
        587785, 601815, 615661, 629320, 642787, 656059, 669130, 681998, 694658,
        707106, 719339, 731353, 743144, 754709, 766044, 777145, 788010, 798635,
        809016, 819152, 829037, 838670, 848048, 857167, 866025, 874619, 882947,
        891006, 898794, 906307, 913545, 920504, 927183, 933580, 939692, 945518,
        951056, 956304, 961261, 965925, 970295, 974370, 978147, 981627, 984807,
        987688, 990268, 992546, 994521, 996194, 997564, 998629, 999390, 999847,
        1000000
    };

    // Quotient magnitude bits of the divider, and its latency in cycles.
    localparam int QUO_BITS = 17;
    localparam int DIV_LAT  = QUO_BITS + 2;

    // Saturation limits.
    localparam logic signed [SCREEN_W-1:0] SCREEN_MAX = 16'sh7FFF;
    localparam logic signed [SCREEN_W-1:0] SCREEN_MIN = 16'sh8000;
    localparam logic [QUO_BITS-1:0] QUO_POS_LIMIT = 17'd32767;
    localparam logic [QUO_BITS-1:0] QUO_NEG_LIMIT = 17'd32768;
    localparam logic signed [DEPTH_W-1:0] DEPTH_MAX = 14'sh1FFF;
    localparam logic signed [DEPTH_W-1:0] DEPTH_MIN = 14'sh2000;

    // One result transaction.
    typedef struct packed {
        logic signed [SCREEN_W-1:0] screen_x;
        logic signed [SCREEN_W-1:0] screen_y;
        logic signed [DEPTH_W-1:0]  depth;
        logic                       divide_fault;
    } result_t;

    // Where an angle falls in the quarter-wave table.
    typedef struct packed {
        logic [SINE_IDX_W-1:0] idx;
        logic                  neg;
        logic                  zero;
    } sine_sel_t;

    // Fold an angle onto the quarter wave.
    function automatic sine_sel_t sine_select(input logic [ANGLE_W-1:0] a);
        sine_sel_t  s;
        logic [9:0] aw;
        aw     = {1'b0, a};
        s.zero = 1'b0;
        s.neg  = 1'b0;
        s.idx  = '0;
        if (aw <= DEG_90) begin
            s.idx = SINE_IDX_W'(aw);
        end else if (aw <= DEG_180) begin
            s.idx = SINE_IDX_W'(DEG_180 - aw);
        end else if (aw <= DEG_270) begin
            s.idx = SINE_IDX_W'(aw - DEG_180);
            s.neg = 1'b1;
        end else if (aw <= DEG_360) begin
            s.idx = SINE_IDX_W'(DEG_360 - aw);
            s.neg = 1'b1;
        end else begin
            s.zero = 1'b1;
        end
        return s;
    endfunction

    // Angle whose sine gives the cosine: (a + 90) mod 360.
    function automatic logic [ANGLE_W-1:0] cosine_angle(input logic [ANGLE_W-1:0] a);
        logic [9:0] t;
        t = {1'b0, a} + DEG_90;
        if (t >= DEG_360) begin
            t = t - DEG_360;
        end
        return ANGLE_W'(t);
    endfunction

endpackage

`default_nettype wire

FILE: src/rpv_if.sv
// Channel interfaces: vertex input, result output and configuration writes.
`timescale 1ns / 1ps
`default_nettype none

interface rpv_vertex_if;
    import rpv_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] vertex_x;
    logic signed [COORD_W-1:0] vertex_y;
    logic signed [COORD_W-1:0] vertex_z;
    logic [ANGLE_W-1:0]        angle_about_x;
    logic [ANGLE_W-1:0]        angle_about_y;
    logic [ANGLE_W-1:0]        angle_about_z;

    modport source (output valid, vertex_x, vertex_y, vertex_z,
                    angle_about_x, angle_about_y, angle_about_z, input ready);
    modport sink   (input valid, vertex_x, vertex_y, vertex_z,
                    angle_about_x, angle_about_y, angle_about_z, output ready);
endinterface

interface rpv_result_if;
    import rpv_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SCREEN_W-1:0] screen_x;
    logic signed [SCREEN_W-1:0] screen_y;
    logic signed [DEPTH_W-1:0]  depth;
    logic                       divide_fault;

    modport source (output valid, screen_x, screen_y, depth, divide_fault, input ready);
    modport sink   (input valid, screen_x, screen_y, depth, divide_fault, output ready);
endinterface

interface rpv_cfg_if;
    import rpv_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: src/rpv_divider.sv
// Pipelined restoring divider with signed numerator and 16-bit saturated quotient.
`timescale 1ns / 1ps
`default_nettype none

module rpv_divider #(
    parameter int NUM_W = 43,
    parameter int DEN_W = 28
) (
    input  wire logic                                clk,
    input  wire logic                                en,
    input  wire logic signed [NUM_W-1:0]             num,
    input  wire logic [DEN_W-1:0]                    den,
    output logic signed [rpv_pkg::SCREEN_W-1:0]      quo
);
    import rpv_pkg::*;

    logic [NUM_W-1:0]    mag_reg [0:QUO_BITS];
    logic [DEN_W-1:0]    rem_reg [0:QUO_BITS];
    logic [DEN_W-1:0]    den_reg [0:QUO_BITS];
    logic [QUO_BITS-1:0] q_reg   [0:QUO_BITS];
    logic                neg_reg [0:QUO_BITS];
    logic                ovf_reg [0:QUO_BITS];
    logic signed [SCREEN_W-1:0] quo_reg;

    logic             neg_next;
    logic [NUM_W-1:0] mag_next;
    logic             ovf_next;

    // Entry: sign, magnitude and a check that the quotient fits its bits.
    always_comb
    begin
        neg_next = num[NUM_W-1];
        mag_next = neg_next ? NUM_W'(-num) : NUM_W'(num);
        ovf_next = (mag_next >> QUO_BITS) >= NUM_W'(den);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg[0] <= mag_next;
            rem_reg[0] <= DEN_W'(mag_next >> QUO_BITS);
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            neg_reg[0] <= neg_next;
            ovf_reg[0] <= ovf_next;
        end
    end

    // One quotient bit per stage, most significant first.
    for (genvar k = 0; k < QUO_BITS; k++)
    begin : g_step
        localparam int BIT = QUO_BITS - 1 - k;
        logic [DEN_W:0]   trial;
        logic             ge;
        logic [DEN_W-1:0] rem_next;

        always_comb
        begin
            trial    = {rem_reg[k], mag_reg[k][BIT]};
            ge       = trial >= {1'b0, den_reg[k]};
            rem_next = ge ? DEN_W'(trial - {1'b0, den_reg[k]}) : DEN_W'(trial);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                mag_reg[k+1] <= mag_reg[k];
                rem_reg[k+1] <= rem_next;
                den_reg[k+1] <= den_reg[k];
                q_reg[k+1]   <= {q_reg[k][QUO_BITS-2:0], ge};
                neg_reg[k+1] <= neg_reg[k];
                ovf_reg[k+1] <= ovf_reg[k];
            end
        end
    end

    // Sign and saturation to the screen width.
    logic signed [SCREEN_W-1:0] quo_next;
    always_comb
    begin
        if (neg_reg[QUO_BITS])
        begin
            if (ovf_reg[QUO_BITS] || (q_reg[QUO_BITS] > QUO_NEG_LIMIT))
                quo_next = SCREEN_MIN;
            else
                quo_next = -SCREEN_W'(q_reg[QUO_BITS]);
        end
        else
        begin
            if (ovf_reg[QUO_BITS] || (q_reg[QUO_BITS] > QUO_POS_LIMIT))
                quo_next = SCREEN_MAX;
            else
                quo_next = SCREEN_W'(q_reg[QUO_BITS]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo_reg <= quo_next;
        end
    end

    assign quo = quo_reg;

endmodule

`default_nettype wire

FILE: src/rotate_project_vertex.sv
// Top level: rotates a vertex about X, Y and Z and projects it onto the screen.
// A vertex passes the 5 stages, then the 17-stage restoring divider, then the output buffer.
// Throughput: one vertex per cycle while the buffer has room; the divider sets the pipe depth.
// The two-entry output buffer lets the pipe keep accepting while a result waits to be taken.
// Reset: rst_n is asynchronous and active low; it empties the pipe and the output buffer
// and loads the configuration registers with their default values.
`timescale 1ns / 1ps
`default_nettype none

module rotate_project_vertex #(
    parameter int SINE_FRAC_BITS = rpv_pkg::SINE_FRAC_BITS_DEFAULT
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    rpv_vertex_if.sink  vertex_in,
    rpv_result_if.source result_out,
    rpv_cfg_if.sink     cfg
);
    import rpv_pkg::*;

    localparam int F   = SINE_FRAC_BITS;
    localparam int SW  = F + 2;
    localparam int CW  = F + 15;
    localparam int PW  = CW + SW;
    localparam int DW  = F + 14;
    localparam int NW  = F + 29;
    localparam int PRE = 5;
    localparam int TOTAL = PRE + DIV_LAT;

    // Configuration registers.
    logic [CFG_W-1:0]        fov_reg;
    logic [CFG_W-1:0]        cam_reg;
    logic signed [CFG_W-1:0] off_x_reg;
    logic signed [CFG_W-1:0] off_y_reg;
    logic signed [CFG_W-1:0] ctr_x_reg;
    logic signed [CFG_W-1:0] ctr_y_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fov_reg   <= FOV_RESET;
            cam_reg   <= CAM_RESET;
            off_x_reg <= OFFSET_X_RESET;
            off_y_reg <= OFFSET_Y_RESET;
            ctr_x_reg <= CENTER_X_RESET;
            ctr_y_reg <= CENTER_Y_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_FIELD_OF_VIEW:   fov_reg   <= cfg.data;
                REG_CAMERA_DISTANCE: cam_reg   <= cfg.data;
                REG_SCREEN_X_OFFSET: off_x_reg <= cfg.data;
                REG_SCREEN_Y_OFFSET: off_y_reg <= cfg.data;
                REG_MODEL_CENTER_X:  ctr_x_reg <= cfg.data;
                REG_MODEL_CENTER_Y:  ctr_y_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    // Sine table at the chosen precision, each entry rounded with halves going up.
    logic signed [SW-1:0] sine_tab [0:SINE_ENTRIES-1];
    for (genvar gi = 0; gi < SINE_ENTRIES; gi++)
    begin : g_tab
        localparam longint ENTRY_Q =
            ((longint'(QUARTER_SINE[gi]) << F) + longint'(SINE_SCALE / 2))
            / longint'(SINE_SCALE);
        assign sine_tab[gi] = SW'(ENTRY_Q);
    end

    function automatic logic signed [SW-1:0] trig(input logic [ANGLE_W-1:0] a);
        sine_sel_t s;
        s = sine_select(a);
        if (s.zero)
            return '0;
        return s.neg ? -sine_tab[s.idx] : sine_tab[s.idx];
    endfunction

    // Round a sum of products back to F fraction bits, halves away from zero.
    localparam logic [PW:0] HALF = (PW+1)'(1) << (F - 1);
    function automatic logic signed [CW-1:0] round_fix(input logic signed [PW:0] p);
        logic [PW:0] m;
        logic [PW:0] r;
        m = p[PW] ? (PW+1)'(-p) : (PW+1)'(p);
        r = (m + HALF) >> F;
        return p[PW] ? -CW'(r) : CW'(r);
    endfunction

    // Pipe control: the pipe moves while the output buffer has room.
    logic [1:0] count_reg;
    logic       en;
    logic       vld_reg [0:TOTAL-1];

    assign en = (count_reg != 2'd2);
    assign vertex_in.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TOTAL; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= vertex_in.valid;
            for (int i = 1; i < TOTAL; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    // Stage 1: centre X and Y of the vertex and look up sine and cosine of all three angles.
    logic signed [12:0]   x0_next, y0_next;
    logic signed [12:0]   x0_reg, y0_reg;
    logic signed [11:0]   z0_reg;
    logic signed [SW-1:0] sx_reg, cx_reg, sy1_reg, cy1_reg, sz1_reg, cz1_reg;

    always_comb
    begin
        x0_next = 13'(vertex_in.vertex_x) - 13'(ctr_x_reg);
        y0_next = 13'(vertex_in.vertex_y) - 13'(ctr_y_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x0_reg  <= x0_next;
            y0_reg  <= y0_next;
            z0_reg  <= vertex_in.vertex_z;
            sx_reg  <= trig(vertex_in.angle_about_x);
            cx_reg  <= trig(cosine_angle(vertex_in.angle_about_x));
            sy1_reg <= trig(vertex_in.angle_about_y);
            cy1_reg <= trig(cosine_angle(vertex_in.angle_about_y));
            sz1_reg <= trig(vertex_in.angle_about_z);
            cz1_reg <= trig(cosine_angle(vertex_in.angle_about_z));
        end
    end

    // Stage 2: rotation about X, exact.
    logic signed [SW+12:0] p_yc, p_zs, p_ys, p_zc;
    logic signed [CW-1:0]  y1_next, z1_next;
    logic signed [CW-1:0]  x1_reg, y1_reg, z1_reg;
    logic signed [SW-1:0]  sy2_reg, cy2_reg, sz2_reg, cz2_reg;

    always_comb
    begin
        p_yc    = y0_reg * cx_reg;
        p_zs    = z0_reg * sx_reg;
        p_ys    = y0_reg * sx_reg;
        p_zc    = z0_reg * cx_reg;
        y1_next = CW'(p_yc) - CW'(p_zs);
        z1_next = CW'(p_ys) + CW'(p_zc);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg  <= CW'(x0_reg) <<< F;
            y1_reg  <= y1_next;
            z1_reg  <= z1_next;
            sy2_reg <= sy1_reg;
            cy2_reg <= cy1_reg;
            sz2_reg <= sz1_reg;
            cz2_reg <= cz1_reg;
        end
    end

    // Stage 3: rotation about Y.
    logic signed [PW-1:0] p_xc, p_zs2, p_zc2, p_xs;
    logic signed [PW:0]   sum_x2, sum_z2;
    logic signed [CW-1:0] x2_reg, z2_reg, y1b_reg;
    logic signed [SW-1:0] sz3_reg, cz3_reg;

    always_comb
    begin
        p_xc   = x1_reg * cy2_reg;
        p_zs2  = z1_reg * sy2_reg;
        p_zc2  = z1_reg * cy2_reg;
        p_xs   = x1_reg * sy2_reg;
        sum_x2 = (PW+1)'(p_xc) + (PW+1)'(p_zs2);
        sum_z2 = (PW+1)'(p_zc2) - (PW+1)'(p_xs);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x2_reg  <= round_fix(sum_x2);
            z2_reg  <= round_fix(sum_z2);
            y1b_reg <= y1_reg;
            sz3_reg <= sz2_reg;
            cz3_reg <= cz2_reg;
        end
    end

    // Stage 4: rotation about Z, depth and the perspective divisor.
    logic signed [PW-1:0]      p_xc3, p_ys3, p_xs3, p_yc3;
    logic signed [PW:0]        sum_x3, sum_y3;
    logic signed [CW-1:0]      z_trunc, cam_q, d_next;
    logic signed [CW-F-1:0]    z_int;
    logic signed [DEPTH_W-1:0] depth_next;
    logic signed [CW-1:0]      x3_reg, y3_reg, d_reg;
    logic signed [DEPTH_W-1:0] depth4_reg;
    logic                      fault4_reg;

    always_comb
    begin
        p_xc3   = x2_reg * cz3_reg;
        p_ys3   = y1b_reg * sz3_reg;
        p_xs3   = x2_reg * sz3_reg;
        p_yc3   = y1b_reg * cz3_reg;
        sum_x3  = (PW+1)'(p_xc3) - (PW+1)'(p_ys3);
        sum_y3  = (PW+1)'(p_xs3) + (PW+1)'(p_yc3);
        // Truncate toward zero: bias negative values before the shift.
        z_trunc = z2_reg[CW-1] ? z2_reg + ((CW'(1) <<< F) - CW'(1)) : z2_reg;
        z_int   = (CW-F)'(z_trunc >>> F);
        if (z_int > (CW-F)'(DEPTH_MAX))
            depth_next = DEPTH_MAX;
        else if (z_int < (CW-F)'(DEPTH_MIN))
            depth_next = DEPTH_MIN;
        else
            depth_next = DEPTH_W'(z_int);
        cam_q   = CW'(cam_reg) <<< F;
        d_next  = z2_reg + cam_q;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x3_reg     <= round_fix(sum_x3);
            y3_reg     <= round_fix(sum_y3);
            d_reg      <= d_next;
            depth4_reg <= depth_next;
            fault4_reg <= d_next[CW-1] || (d_next == '0);
        end
    end

    // Stage 5: numerators fov * v + offset * D.
    logic signed [CW+12:0]     p_fx, p_fy;
    logic signed [CW+11:0]     p_ox, p_oy;
    logic signed [NW-1:0]      num_x_reg, num_y_reg;
    logic [DW-1:0]             den_reg;
    logic signed [DEPTH_W-1:0] depth5_reg;
    logic                      fault5_reg;

    always_comb
    begin
        p_fx = $signed({1'b0, fov_reg}) * x3_reg;
        p_fy = $signed({1'b0, fov_reg}) * y3_reg;
        p_ox = off_x_reg * d_reg;
        p_oy = off_y_reg * d_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_x_reg  <= NW'(p_fx) + NW'(p_ox);
            num_y_reg  <= NW'(p_fy) + NW'(p_oy);
            den_reg    <= d_reg[DW-1:0];
            depth5_reg <= depth4_reg;
            fault5_reg <= fault4_reg;
        end
    end

    // Dividers for screen x and y.
    logic signed [SCREEN_W-1:0] qx, qy;

    rpv_divider #(.NUM_W(NW), .DEN_W(DW)) u_div_x (
        .clk (clk),
        .en  (en),
        .num (num_x_reg),
        .den (den_reg),
        .quo (qx)
    );

    rpv_divider #(.NUM_W(NW), .DEN_W(DW)) u_div_y (
        .clk (clk),
        .en  (en),
        .num (num_y_reg),
        .den (den_reg),
        .quo (qy)
    );

    // Depth and fault travel beside the dividers.
    logic signed [DEPTH_W-1:0] depth_pipe_reg [0:DIV_LAT-1];
    logic                      fault_pipe_reg [0:DIV_LAT-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            depth_pipe_reg[0] <= depth5_reg;
            fault_pipe_reg[0] <= fault5_reg;
            for (int i = 1; i < DIV_LAT; i++)
            begin
                depth_pipe_reg[i] <= depth_pipe_reg[i-1];
                fault_pipe_reg[i] <= fault_pipe_reg[i-1];
            end
        end
    end

    // Assemble the result; a fault forces the screen position to zero.
    result_t res_next;
    always_comb
    begin
        res_next.divide_fault = fault_pipe_reg[DIV_LAT-1];
        res_next.depth        = depth_pipe_reg[DIV_LAT-1];
        res_next.screen_x     = res_next.divide_fault ? '0 : qx;
        res_next.screen_y     = res_next.divide_fault ? '0 : qy;
    end

    // Two-entry output buffer.
    result_t buf_reg [0:1];
    logic    wr_ptr_reg, rd_ptr_reg;
    logic    push, pop;

    assign push = en && vld_reg[TOTAL-1];
    assign pop  = result_out.valid && result_out.ready;

    always_ff @(posedge clk)
    begin
        if (push)
            buf_reg[wr_ptr_reg] <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    assign result_out.valid        = (count_reg != 2'd0);
    assign result_out.screen_x     = buf_reg[rd_ptr_reg].screen_x;
    assign result_out.screen_y     = buf_reg[rd_ptr_reg].screen_y;
    assign result_out.depth        = buf_reg[rd_ptr_reg].depth;
    assign result_out.divide_fault = buf_reg[rd_ptr_reg].divide_fault;

`ifndef SYNTHESIS
    // The output buffer never holds more than two results.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("output buffer count out of range");

    // An accepted vertex occupies the first stage on the next cycle.
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (vertex_in.valid && vertex_in.ready) |=> vld_reg[0])
        else $error("accepted vertex missing from first stage");

    // A faulted result always carries a zero screen position.
    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_out.valid && result_out.divide_fault) |->
            (result_out.screen_x == '0 && result_out.screen_y == '0))
        else $error("faulted result with non-zero position");

    // A full buffer with no pop stays full and the pipe holds.
    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd2 && !pop) |=> (count_reg == 2'd2))
        else $error("full output buffer lost an entry");
`endif

endmodule

`default_nettype wire
